FILE: design/rmil_pkg.sv
// ----------------------------------------------------------------------------
// rmil_pkg
// Shared types and codes for the row-major index linearizer.
// ----------------------------------------------------------------------------
package rmil_pkg;

	localparam int NUM_LANES = 4;
	localparam int IDX_W     = 16;
	localparam int OFF_W     = 64;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_SHAPE_ZERO = 3'd1,
		ST_INDEX_ZERO = 3'd2,
		ST_RANK_MISM  = 3'd3,
		ST_OUT_BOUNDS = 3'd4,
		ST_OFF_LARGE  = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		REG_RANK  = 3'd0,
		REG_DIM_0 = 3'd1,
		REG_DIM_1 = 3'd2,
		REG_DIM_2 = 3'd3,
		REG_DIM_3 = 3'd4
	} reg_idx_t;

	localparam logic CMD_TO_OFFSET = 1'b0;
	localparam logic CMD_TO_INDEX  = 1'b1;

	typedef struct packed {
		logic        command;
		logic [2:0]  index_rank;
		logic [15:0] index_0;
		logic [15:0] index_1;
		logic [15:0] index_2;
		logic [15:0] index_3;
		logic [63:0] offset_in;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] offset_out;
		logic [15:0] result_index_0;
		logic [15:0] result_index_1;
		logic [15:0] result_index_2;
		logic [15:0] result_index_3;
	} rsp_t;

	typedef struct packed {
		status_t           status;
		logic              cmd;
		logic [OFF_W-1:0]  offset;
	} meta_t;

	typedef struct packed {
		meta_t                             meta;
		logic [OFF_W-1:0]                  rem;
		logic [NUM_LANES-1:0][IDX_W-1:0]   res;
	} lane_t;

endpackage

FILE: design/row_major_index_linearizer_core.sv
// ----------------------------------------------------------------------------
// row_major_index_linearizer_core
// Converts index vectors to row-major offsets and back for a configured shape.
// ----------------------------------------------------------------------------
// Takes one beat per cycle while the output beat is not stalled and returns one
// beat per request, in order. The pipeline is a settle line while the stride
// registers follow the shape, a check stage, a lane product sum, then one
// divide lane per dimension that resolves one quotient bit per stage, and
// the output register. The whole pipeline holds while the output beat is
// stalled.
module row_major_index_linearizer_core #(
	parameter int MAX_RANK = 4,
	parameter int DIM_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  rmil_pkg::req_t       req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rmil_pkg::rsp_t       rsp,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [15:0]          cfg_data
);
	import rmil_pkg::*;

	localparam int NL     = (MAX_RANK < NUM_LANES) ? MAX_RANK : NUM_LANES;
	localparam int SETTLE = NL + 1;
	localparam logic [IDX_W-1:0] DIM_MASK = IDX_W'((32'd1 << DIM_BITS) - 1);

	logic [2:0]                      rank_q;
	logic [NUM_LANES-1:0][IDX_W-1:0] dim_q;
	logic [NUM_LANES-1:0][OFF_W-1:0] stride;
	logic [OFF_W-1:0]                size;
	logic [2:0]                      srank;
	logic                            adv;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q <= '0;
			dim_q  <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_RANK:  rank_q   <= cfg_data[2:0];
				REG_DIM_0: dim_q[0] <= cfg_data & DIM_MASK;
				REG_DIM_1: dim_q[1] <= cfg_data & DIM_MASK;
				REG_DIM_2: dim_q[2] <= cfg_data & DIM_MASK;
				REG_DIM_3: dim_q[3] <= cfg_data & DIM_MASK;
				default:   ;
			endcase
		end
	end

	assign srank = (rank_q > 3'(NL)) ? 3'(NL) : rank_q;

	rmil_stride u_stride (
		.clk    (clk),
		.arst_n (arst_n),
		.srank  (srank),
		.dim    (dim_q),
		.stride (stride),
		.size   (size)
	);

	assign adv       = !rsp_valid || !rsp_stall;
	assign req_stall = !adv;

	// settle line
	logic [SETTLE-1:0] dl_v_q;
	req_t              dl_q [SETTLE];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dl_v_q <= '0;
		end else if (adv) begin
			dl_v_q <= {dl_v_q[SETTLE-2:0], req_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dl_q[0] <= req;
			for (int k = 1; k < SETTLE; k++) begin
				dl_q[k] <= dl_q[k-1];
			end
		end
	end

	// check stage
	req_t                            ck;
	logic [2:0]                      irank;
	logic [NUM_LANES-1:0][IDX_W-1:0] idx;
	logic                            oob;
	status_t                         ck_status;
	logic [NUM_LANES-1:0][OFF_W-1:0] prod;

	assign ck    = dl_q[SETTLE-1];
	assign irank = (ck.index_rank > 3'(NL)) ? 3'(NL) : ck.index_rank;
	assign idx   = {ck.index_3 & DIM_MASK, ck.index_2 & DIM_MASK,
	                ck.index_1 & DIM_MASK, ck.index_0 & DIM_MASK};

	always_comb begin
		oob = 1'b0;
		for (int d = 0; d < NUM_LANES; d++) begin
			if ((3'(d) < srank) && (idx[d] >= dim_q[d])) begin
				oob = 1'b1;
			end
			prod[d] = OFF_W'(idx[d] * stride[d]);
		end
		if (srank == '0) begin
			ck_status = ST_SHAPE_ZERO;
		end else if (irank == '0) begin
			ck_status = ST_INDEX_ZERO;
		end else if (irank != srank) begin
			ck_status = ST_RANK_MISM;
		end else if (ck.command == CMD_TO_OFFSET) begin
			ck_status = oob ? ST_OUT_BOUNDS : ST_OK;
		end else begin
			ck_status = (ck.offset_in >= size) ? ST_OFF_LARGE : ST_OK;
		end
	end

	logic                            ck_v_s1;
	status_t                         ck_status_s1;
	logic                            ck_cmd_s1;
	logic [OFF_W-1:0]                ck_off_s1;
	logic [NUM_LANES-1:0][OFF_W-1:0] prod_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ck_v_s1 <= 1'b0;
		end else if (adv) begin
			ck_v_s1 <= dl_v_q[SETTLE-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ck_status_s1 <= ck_status;
			ck_cmd_s1    <= ck.command;
			ck_off_s1    <= ck.offset_in;
			prod_s1      <= prod;
		end
	end

	// sum lane products, start the split
	logic  sum_v_s2;
	lane_t sum_s2;
	lane_t sum_nxt;

	always_comb begin
		sum_nxt             = '0;
		sum_nxt.meta.status = ck_status_s1;
		sum_nxt.meta.cmd    = ck_cmd_s1;
		sum_nxt.rem         = ck_off_s1;
		for (int d = 0; d < NUM_LANES; d++) begin
			sum_nxt.meta.offset = sum_nxt.meta.offset + prod_s1[d];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_v_s2 <= 1'b0;
		end else if (adv) begin
			sum_v_s2 <= ck_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s2 <= sum_nxt;
		end
	end

	// divide lanes, one per dimension
	logic  ln_v [NL+1];
	lane_t ln_p [NL+1];

	assign ln_v[0] = sum_v_s2;
	assign ln_p[0] = sum_s2;

	for (genvar l = 0; l < NL; l++) begin : g_lane
		rmil_lane #(
			.LANE  (l),
			.QBITS (DIM_BITS)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.stride (stride[l]),
			.in_v   (ln_v[l]),
			.in_p   (ln_p[l]),
			.out_v  (ln_v[l+1]),
			.out_p  (ln_p[l+1])
		);
	end

	// merge into the output beat
	lane_t fin;
	rsp_t  rsp_nxt;
	logic  rsp_valid_q;
	rsp_t  rsp_q;

	assign fin = ln_p[NL];

	always_comb begin
		rsp_nxt        = '0;
		rsp_nxt.status = fin.meta.status;
		if (fin.meta.status == ST_OK) begin
			if (fin.meta.cmd == CMD_TO_OFFSET) begin
				rsp_nxt.offset_out = fin.meta.offset;
			end else begin
				rsp_nxt.result_index_0 = fin.res[0];
				rsp_nxt.result_index_1 = fin.res[1];
				rsp_nxt.result_index_2 = fin.res[2];
				rsp_nxt.result_index_3 = fin.res[3];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= ln_v[NL];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: design/rmil_stride.sv
// ----------------------------------------------------------------------------
// rmil_stride
// Registered stride and total size of the configured shape.
// ----------------------------------------------------------------------------
module rmil_stride (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic [2:0]                                    srank,
	input  logic [rmil_pkg::NUM_LANES-1:0][rmil_pkg::IDX_W-1:0] dim,
	output logic [rmil_pkg::NUM_LANES-1:0][rmil_pkg::OFF_W-1:0] stride,
	output logic [rmil_pkg::OFF_W-1:0]                    size
);
	import rmil_pkg::*;

	logic [NUM_LANES-1:0][OFF_W-1:0] stride_q;
	logic [OFF_W-1:0]                size_q;

	// each stride settles in the cycle after the one above it
	for (genvar d = 0; d < NUM_LANES; d++) begin : g_str
		if (d == NUM_LANES - 1) begin : g_last
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					stride_q[d] <= '0;
				end else begin
					stride_q[d] <= (3'(d) == srank - 3'd1) ? OFF_W'(1) : '0;
				end
			end
		end else begin : g_mid
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					stride_q[d] <= '0;
				end else if (3'(d) >= srank) begin
					stride_q[d] <= '0;
				end else if (3'(d) == srank - 3'd1) begin
					stride_q[d] <= OFF_W'(1);
				end else begin
					stride_q[d] <= OFF_W'(stride_q[d+1] * dim[d+1]);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= '0;
		end else begin
			size_q <= OFF_W'(stride_q[0] * dim[0]);
		end
	end

	assign stride = stride_q;
	assign size   = size_q;

endmodule

FILE: design/rmil_lane.sv
// ----------------------------------------------------------------------------
// rmil_lane
// One dimension of the offset split: restoring divide, one quotient bit
// per pipeline stage.
// ----------------------------------------------------------------------------
module rmil_lane #(
	parameter int LANE  = 0,
	parameter int QBITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic [rmil_pkg::OFF_W-1:0]    stride,
	input  logic                          in_v,
	input  rmil_pkg::lane_t               in_p,
	output logic                          out_v,
	output rmil_pkg::lane_t               out_p
);
	import rmil_pkg::*;

	localparam int TW = OFF_W + IDX_W;

	logic  [QBITS-1:0] v_s;
	lane_t             p_s [QBITS];

	for (genvar j = 0; j < QBITS; j++) begin : g_bit
		localparam int BIT = QBITS - 1 - j;
		logic          src_v;
		lane_t         src_p;
		lane_t         nxt_p;
		logic [TW-1:0] trial;
		logic          take;

		if (j == 0) begin : g_first
			assign src_v = in_v;
			assign src_p = in_p;
		end else begin : g_next
			assign src_v = v_s[j-1];
			assign src_p = p_s[j-1];
		end

		always_comb begin
			trial = {{IDX_W{1'b0}}, stride} << BIT;
			take  = (stride != '0) && (trial <= {{IDX_W{1'b0}}, src_p.rem});
			nxt_p = src_p;
			if (take) begin
				nxt_p.rem            = src_p.rem - trial[OFF_W-1:0];
				nxt_p.res[LANE][BIT] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (adv) begin
				v_s[j] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				p_s[j] <= nxt_p;
			end
		end
	end

	assign out_v = v_s[QBITS-1];
	assign out_p = p_s[QBITS-1];

endmodule

FILE: dv/tb_row_major_index_linearizer_core.sv
// ----------------------------------------------------------------------------
// tb_row_major_index_linearizer_core
// Self-checking bench for the row-major index/offset converter.
// ----------------------------------------------------------------------------
// Programs a series of array shapes and sends index-to-offset and
// offset-to-index requests: a directed table first, then random beats that
// are mostly legal for the current shape. Every response is compared field by
// field against an in-bench predictor, in order; most random beats run under random idle and stall.
module tb_row_major_index_linearizer_core;
	timeunit 1ns;
	timeprecision 1ps;
	import rmil_pkg::*;

	localparam int LATENCY   = 4 + 4 + 4 * 16;
	localparam int WDOG_MAX  = 20000;
	localparam int N_RANDOM  = 950;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	req_t        req;
	logic        rsp_valid;
	logic        rsp_stall;
	rsp_t        rsp;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	row_major_index_linearizer_core uut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// shape copy used by the predictor
	logic [2:0]  shape_rank;
	logic [15:0] shape_dim [4];

	rsp_t pending_rsp [$];
	int   errors;
	int   n_sent;
	int   n_checked;
	int   n_ok;
	int   n_err_beats;
	int   idle_pct;
	int   stall_pct;
	int   wdog;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic rsp_t linearize(input req_t r);
		rsp_t        o;
		int unsigned srank;
		int unsigned irank;
		logic [63:0] stride [4];
		logic [63:0] idx [4];
		logic [63:0] total;
		logic [63:0] rem;
		logic [15:0] res [4];
		o = '0;
		total = 64'd1;
		srank = (shape_rank > 3'd4) ? 4 : shape_rank;
		irank = (r.index_rank > 3'd4) ? 4 : r.index_rank;
		idx[0] = r.index_0;
		idx[1] = r.index_1;
		idx[2] = r.index_2;
		idx[3] = r.index_3;
		for (int d = 0; d < 4; d++) begin
			stride[d] = '0;
			res[d] = '0;
		end
		if (srank > 0) begin
			stride[srank-1] = 64'd1;
			for (int d = int'(srank) - 1; d > 0; d--)
				stride[d-1] = stride[d] * shape_dim[d];
			for (int d = 0; d < int'(srank); d++)
				total = total * shape_dim[d];
		end
		o.status = ST_OK;
		if (srank == 0)
			o.status = ST_SHAPE_ZERO;
		else if (irank == 0)
			o.status = ST_INDEX_ZERO;
		else if (irank != srank)
			o.status = ST_RANK_MISM;
		else if (r.command == CMD_TO_OFFSET) begin
			for (int d = 0; d < int'(srank); d++) begin
				if (idx[d] >= shape_dim[d]) begin
					o.status = ST_OUT_BOUNDS;
					break;
				end
				o.offset_out = o.offset_out + idx[d] * stride[d];
			end
			if (o.status != ST_OK)
				o.offset_out = '0;
		end else begin
			rem = r.offset_in;
			if (rem >= total)
				o.status = ST_OFF_LARGE;
			else begin
				for (int d = 0; d < int'(srank); d++) begin
					if (stride[d] != 0) begin
						res[d] = 16'(rem / stride[d]);
						rem = rem % stride[d];
					end
				end
				o.result_index_0 = res[0];
				o.result_index_1 = res[1];
				o.result_index_2 = res[2];
				o.result_index_3 = res[3];
			end
		end
		return o;
	endfunction

	task automatic wait_idle();
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
	endtask

	// leave valid up so that writes can follow back to back
	task automatic write_reg(input reg_idx_t ri, input logic [15:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= ri;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (ri)
			REG_RANK:  shape_rank = v[2:0];
			REG_DIM_0: shape_dim[0] = v;
			REG_DIM_1: shape_dim[1] = v;
			REG_DIM_2: shape_dim[2] = v;
			REG_DIM_3: shape_dim[3] = v;
			default: ;
		endcase
	endtask

	task automatic set_shape(input logic [2:0] rk, input logic [15:0] d0,
			input logic [15:0] d1, input logic [15:0] d2, input logic [15:0] d3);
		wait_idle();
		write_reg(REG_RANK, {13'd0, rk});
		write_reg(REG_DIM_0, d0);
		write_reg(REG_DIM_1, d1);
		write_reg(REG_DIM_2, d2);
		write_reg(REG_DIM_3, d3);
		cfg_valid <= 1'b0;
	endtask

	// hold valid across back-to-back beats; drop only on a random idle
	task automatic send_beat(input req_t r);
		while ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		pending_rsp.push_back(linearize(r));
		n_sent++;
	endtask

	task automatic drop_valid();
		req_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [15:0] pick_in(input logic [15:0] ext);
		int unsigned m;
		m = $urandom_range(9);
		if (m == 0 || ext == 0)
			return 16'($urandom);
		else if (m == 1)
			return ext - 16'd1;
		else
			return 16'($urandom_range(ext - 1));
	endfunction

	function automatic req_t random_beat();
		req_t        r;
		logic [63:0] total;
		int unsigned sr;
		r = '0;
		r.command = 1'($urandom);
		r.index_0 = pick_in(shape_dim[0]);
		r.index_1 = pick_in(shape_dim[1]);
		r.index_2 = pick_in(shape_dim[2]);
		r.index_3 = pick_in(shape_dim[3]);
		r.index_rank = ($urandom_range(9) < 8) ? shape_rank : 3'($urandom);
		sr = (shape_rank > 3'd4) ? 4 : shape_rank;
		total = 64'd1;
		for (int d = 0; d < int'(sr); d++)
			total = total * shape_dim[d];
		case ($urandom_range(9))
			0: r.offset_in = {$urandom, $urandom};
			1: r.offset_in = total;
			2: r.offset_in = (total == 0) ? 64'd0 : total - 64'd1;
			default: r.offset_in = (total == 0) ? 64'd0
				: {$urandom, $urandom} % total;
		endcase
		return r;
	endfunction

	// directed rows: shape, request, and where obvious the expected status
	typedef struct {
		logic [2:0]  rk;
		logic [15:0] d0, d1, d2, d3;
		req_t        r;
		bit          has_exp;
		status_t     exp_status;
	} dir_row_t;

	function automatic req_t mk(input logic c, input logic [2:0] ir, input logic [15:0] i0,
			input logic [15:0] i1, input logic [15:0] i2, input logic [15:0] i3,
			input logic [63:0] o);
		req_t r;
		r.command = c; r.index_rank = ir;
		r.index_0 = i0; r.index_1 = i1; r.index_2 = i2; r.index_3 = i3;
		r.offset_in = o;
		return r;
	endfunction

	// consumer: random stall, in-order compare
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (pending_rsp.size() == 0) begin
					$display("%0t: unexpected beat, expected none, actual %p", $realtime, rsp);
					errors++;
				end else begin
					rsp_t e;
					e = pending_rsp.pop_front();
					n_checked++;
					if (e.status == ST_OK) n_ok++; else n_err_beats++;
					if (rsp.status !== e.status) begin
						$display("%0t: status expected %0d actual %0d", $realtime,
							e.status, rsp.status);
						errors++;
					end
					if (rsp.offset_out !== e.offset_out) begin
						$display("%0t: offset_out expected %0h actual %0h", $realtime,
							e.offset_out, rsp.offset_out);
						errors++;
					end
					if (rsp.result_index_0 !== e.result_index_0) begin
						$display("%0t: result_index_0 expected %0h actual %0h", $realtime,
							e.result_index_0, rsp.result_index_0);
						errors++;
					end
					if (rsp.result_index_1 !== e.result_index_1) begin
						$display("%0t: result_index_1 expected %0h actual %0h", $realtime,
							e.result_index_1, rsp.result_index_1);
						errors++;
					end
					if (rsp.result_index_2 !== e.result_index_2) begin
						$display("%0t: result_index_2 expected %0h actual %0h", $realtime,
							e.result_index_2, rsp.result_index_2);
						errors++;
					end
					if (rsp.result_index_3 !== e.result_index_3) begin
						$display("%0t: result_index_3 expected %0h actual %0h", $realtime,
							e.result_index_3, rsp.result_index_3);
						errors++;
					end
				end
			end
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// watchdog: cycles with no beat or register write
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
				|| (cfg_valid && cfg_ready))
			wdog <= 0;
		else
			wdog <= wdog + 1;
		if (wdog >= WDOG_MAX) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		dir_row_t dir [$];
		req_t     r;
		rsp_t     e;
		errors = 0; n_sent = 0; n_checked = 0; n_ok = 0; n_err_beats = 0; wdog = 0;
		idle_pct = 0; stall_pct = 0;
		arst_n = 1'b0;
		req_valid = 1'b0; req = '0;
		rsp_stall = 1'b0;
		cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
		shape_rank = '0;
		for (int d = 0; d < 4; d++) shape_dim[d] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset shape: rank zero
		dir.push_back('{3'd0, 16'd0, 16'd0, 16'd0, 16'd0,
			mk(CMD_TO_OFFSET, 3'd1, 0, 0, 0, 0, 0), 1, ST_SHAPE_ZERO});
		dir.push_back('{3'd0, 16'd0, 16'd0, 16'd0, 16'd0,
			mk(CMD_TO_INDEX, 3'd4, 0, 0, 0, 0, 0), 1, ST_SHAPE_ZERO});
		dir.push_back('{3'd3, 16'd4, 16'd5, 16'd6, 16'd0,
			mk(CMD_TO_OFFSET, 3'd0, 0, 0, 0, 0, 0), 1, ST_INDEX_ZERO});
		dir.push_back('{3'd3, 16'd4, 16'd5, 16'd6, 16'd0,
			mk(CMD_TO_INDEX, 3'd0, 0, 0, 0, 0, 0), 1, ST_INDEX_ZERO});
		dir.push_back('{3'd3, 16'd4, 16'd5, 16'd6, 16'd0,
			mk(CMD_TO_OFFSET, 3'd2, 0, 0, 0, 0, 0), 1, ST_RANK_MISM});
		dir.push_back('{3'd3, 16'd4, 16'd5, 16'd6, 16'd0,
			mk(CMD_TO_OFFSET, 3'd3, 3, 4, 5, 16'hFFFF, 0), 0, ST_OK});
		dir.push_back('{3'd3, 16'd4, 16'd5, 16'd6, 16'd0,
			mk(CMD_TO_OFFSET, 3'd3, 4, 0, 0, 0, 0), 1, ST_OUT_BOUNDS});
		dir.push_back('{3'd3, 16'd4, 16'd5, 16'd6, 16'd0,
			mk(CMD_TO_INDEX, 3'd3, 0, 0, 0, 0, 119), 0, ST_OK});
		dir.push_back('{3'd3, 16'd4, 16'd5, 16'd6, 16'd0,
			mk(CMD_TO_INDEX, 3'd3, 0, 0, 0, 0, 120), 1, ST_OFF_LARGE});
		dir.push_back('{3'd3, 16'd4, 16'd5, 16'd6, 16'd0,
			mk(CMD_TO_INDEX, 3'd3, 0, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF), 1, ST_OFF_LARGE});
		// oversized ranks saturate to four
		dir.push_back('{3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			mk(CMD_TO_OFFSET, 3'd5, 16'hFFFE, 16'hFFFE, 16'hFFFE, 16'hFFFE, 0), 0, ST_OK});
		dir.push_back('{3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			mk(CMD_TO_OFFSET, 3'd7, 16'hFFFF, 0, 0, 0, 0), 1, ST_OUT_BOUNDS});
		dir.push_back('{3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			mk(CMD_TO_INDEX, 3'd6, 0, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF), 0, ST_OK});
		dir.push_back('{3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			mk(CMD_TO_INDEX, 3'd4, 0, 0, 0, 0, 64'hFFFC_0005_FFFC_0000), 0, ST_OK});
		// zero extent
		dir.push_back('{3'd2, 16'd0, 16'd9, 16'd0, 16'd0,
			mk(CMD_TO_OFFSET, 3'd2, 0, 0, 0, 0, 0), 1, ST_OUT_BOUNDS});
		dir.push_back('{3'd2, 16'd0, 16'd9, 16'd0, 16'd0,
			mk(CMD_TO_INDEX, 3'd2, 0, 0, 0, 0, 0), 1, ST_OFF_LARGE});
		// rank one, unused lanes ignored
		dir.push_back('{3'd1, 16'd10, 16'd3, 16'd3, 16'd3,
			mk(CMD_TO_OFFSET, 3'd1, 9, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0), 0, ST_OK});
		dir.push_back('{3'd1, 16'd10, 16'd3, 16'd3, 16'd3,
			mk(CMD_TO_INDEX, 3'd1, 0, 0, 0, 0, 7), 0, ST_OK});

		foreach (dir[i]) begin
			if (i == 0 || dir[i].rk != shape_rank || dir[i].d0 != shape_dim[0]
					|| dir[i].d1 != shape_dim[1] || dir[i].d2 != shape_dim[2]
					|| dir[i].d3 != shape_dim[3]) begin
				drop_valid();
				set_shape(dir[i].rk, dir[i].d0, dir[i].d1, dir[i].d2, dir[i].d3);
			end
			e = linearize(dir[i].r);
			if (dir[i].has_exp && e.status != dir[i].exp_status) begin
				$display("%0t: table row %0d status expected %0d actual %0d", $realtime,
					i, dir[i].exp_status, e.status);
				errors++;
			end
			send_beat(dir[i].r);
		end
		drop_valid();
		// unknown register index: must leave the shape alone
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= 3'd6;
		cfg_data  <= 16'hFFFF;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		send_beat(mk(CMD_TO_INDEX, 3'd1, 0, 0, 0, 0, 5));
		drop_valid();

		for (int ph = 0; ph < 3; ph++) begin
			idle_pct  = (ph == 0) ? 32 : (ph == 1) ? 61 : 0;
			stall_pct = (ph == 0) ? 61 : (ph == 1) ? 32 : 0;
			for (int s = 0; s < 8; s++) begin
				logic [2:0] rk;
				logic [15:0] dd [4];
				rk = (s == 7) ? 3'($urandom) : 3'($urandom_range(4, 1));
				for (int d = 0; d < 4; d++) begin
					case ($urandom_range(7))
						0: dd[d] = 16'hFFFF;
						1: dd[d] = 16'd1;
						2: dd[d] = 16'($urandom);
						3: dd[d] = (s == 6) ? 16'd0 : 16'd2;
						default: dd[d] = 16'($urandom_range(40, 1));
					endcase
				end
				drop_valid();
				set_shape(rk, dd[0], dd[1], dd[2], dd[3]);
				for (int k = 0; k < N_RANDOM / 24; k++) begin
					r = random_beat();
					send_beat(r);
				end
			end
		end
		drop_valid();

		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
		$display("Sent %0d requests across 29 shapes, checked %0d responses", n_sent, n_checked);
		$display("  %0d converted cleanly, %0d returned an error status", n_ok, n_err_beats);
		if (errors == 0 && pending_rsp.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
